// ===== src/ilha_pkg.sv =====
// package: constants, types and tag helpers for the implicit-list heap allocator
`default_nettype none
package ilha_pkg;

  localparam int unsigned HeapWords = 16384;
  localparam int unsigned AddrW     = $clog2(HeapWords);
  localparam int unsigned ByteW     = AddrW + 3;
  localparam int unsigned AW        = 33;

  localparam logic [16:0] ChunkReset = 17'd4096;
  localparam logic [31:0] TagUsed    = 32'h1;
  localparam logic [31:0] SizeMask   = 32'hFFFF_FFF8;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOMEM = 2'd1,
    ST_NULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [15:0] copy_bytes;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] request_bytes;
    logic [15:0] block_address;
  } request_t;

  // request size rounded up to a block size
  function automatic logic [31:0] block_for(input logic [15:0] n);
    logic [31:0] t;
    begin
      t = {16'd0, n} + 32'd15;
      block_for = (n <= 16'd8) ? 32'd16 : {t[31:3], 3'b000};
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/ilha_stream_if.sv =====
// interfaces: valid/ready channels for requests and results
`default_nettype none
interface ilha_req_if;
  logic                 valid;
  logic                 ready;
  ilha_pkg::request_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ilha_res_if;
  logic                 valid;
  logic                 ready;
  ilha_pkg::result_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ilha_ram.sv =====
// heap word memory: one write port, one registered read port
`default_nettype none
module ilha_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ilha_pkg::AddrW-1:0] waddr,
  input  wire logic [31:0]               wdata,
  input  wire logic [ilha_pkg::AddrW-1:0] raddr,
  output      logic [31:0]               rdata
);
  import ilha_pkg::*;

  logic [31:0] mem [HeapWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/implicit_list_heap_allocator.sv =====
// top level: implicit free list, first-fit heap allocator with boundary tags
//
// in channel carries one request (mode, request_bytes, block_address); out
// channel returns exactly one result per request (result_address, copy_bytes,
// status). cfg_we/cfg_wdata write chunk_bytes; the user must do so only while
// idle, the block does not enforce it. the heap tags live in one word memory
// with a registered read; a sequencer walks the blocks, reading each tag by
// address, then data, and writing tags one per cycle. one request is handled
// at a time.
// after reset the sequencer first clears all 16384 words, one per cycle, then
// lays down padding, prologue, epilogue and one chunk; in.ready is low
// during this pass.
// results sit in an output register; while the receiver stalls the result
// is held and no new request is taken.
// reads outside memory give zero, writes outside memory are dropped.
`default_nettype none
module implicit_list_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  ilha_req_if.sink         in_ch,
  ilha_res_if.source       out_ch
);
  import ilha_pkg::*;

  // micro-op states; read states issue an address, the next state uses data
  typedef enum logic [5:0] {
    S_CLR, S_INIT, S_IDLE, S_DISPATCH,
    // grow
    S_GR0, S_GR1, S_GR2, S_GR3,
    // merge
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG6, S_MG7, S_MG8,
    // first fit
    S_FF0, S_FF1,
    // carve
    S_CV0, S_CV1, S_CV2, S_CV3, S_CV4,
    // alloc after fit or grow
    S_AL0,
    // free
    S_FR0, S_FR1, S_FR2,
    // realloc
    S_RA0, S_RA1, S_RA2, S_RA3, S_RA4, S_RA5, S_RA6, S_RA7,
    S_OUT
  } seq_t;

  // who called grow / merge / alloc
  typedef enum logic [1:0] { RET_INIT, RET_ALLOC, RET_RA, RET_FREE } ret_t;

  seq_t            st_r, st_nxt;
  ret_t            gret_r, gret_nxt, mret_r, mret_nxt, aret_r, aret_nxt;
  logic [16:0]     chunk_r;
  logic [AW-1:0]   brk_r, brk_nxt;
  logic [AW-1:0]   bp_r, bp_nxt, p_r, p_nxt, n_r, n_nxt, ptr_r, ptr_nxt;
  logic [31:0]     sz_r, sz_nxt, a_r, a_nxt, b_r, b_nxt, need_r, need_nxt;
  logic [31:0]     old_r, old_nxt;
  logic            pu_r, pu_nxt, ok_r, ok_nxt;
  logic [AddrW:0]  clr_r, clr_nxt;
  request_t        req_r, req_nxt;
  result_t         res_r, res_nxt;
  logic            ov_r, ov_nxt;

  // memory port
  logic            rd_valid_r, rd_valid_nxt;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   wa;
  logic [31:0]     wd;
  logic            we;
  logic [31:0]     ram_q;
  logic [31:0]     rq;

  ilha_ram u_ram (
    .clk   (clk),
    .we    (we && wa[AW-1:2] < AW'(HeapWords) && !wa[AW-1]),
    .waddr (wa[AddrW+1:2]),
    .wdata (wd),
    .raddr (ra[AddrW+1:2]),
    .rdata (ram_q)
  );

  // out-of-range reads read zero
  assign rq = rd_valid_r ? ram_q : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      chunk_r <= ChunkReset;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      brk_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      brk_r   <= brk_nxt;
      if (cfg_we) begin
        chunk_r <= cfg_wdata;
      end
    end
    gret_r <= gret_nxt; mret_r <= mret_nxt; aret_r <= aret_nxt;
    bp_r <= bp_nxt; p_r <= p_nxt; n_r <= n_nxt; ptr_r <= ptr_nxt;
    sz_r <= sz_nxt; a_r <= a_nxt; b_r <= b_nxt; need_r <= need_nxt;
    old_r <= old_nxt; pu_r <= pu_nxt; ok_r <= ok_nxt;
    req_r <= req_nxt; res_r <= res_nxt; rd_valid_r <= rd_valid_nxt;
  end

  assign in_ch.ready  = (st_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  // grow extension: words rounded to even, times four
  function automatic logic [AW-1:0] grow_bytes(input logic [31:0] bytes_in);
    logic [AW-1:0] w;
    begin
      w = AW'(bytes_in[31:2]);
      grow_bytes = {w[AW-3:0] + {{(AW-3){1'b0}}, w[0]}, 2'b00};
    end
  endfunction

  logic [AW-1:0] gsz;
  logic [31:0]   ext;
  logic [31:0]   cpy;

  always_comb begin
    st_nxt = st_r; gret_nxt = gret_r; mret_nxt = mret_r; aret_nxt = aret_r;
    bp_nxt = bp_r; p_nxt = p_r; n_nxt = n_r; ptr_nxt = ptr_r;
    sz_nxt = sz_r; a_nxt = a_r; b_nxt = b_r; need_nxt = need_r;
    old_nxt = old_r; pu_nxt = pu_r; ok_nxt = ok_r;
    clr_nxt = clr_r; req_nxt = req_r; res_nxt = res_r; brk_nxt = brk_r;
    ov_nxt = ov_r && !out_ch.ready;
    ra = '0; we = 1'b0; wa = '0; wd = '0;
    gsz = grow_bytes(a_r);
    ext = (need_r > {15'd0, chunk_r}) ? need_r : {15'd0, chunk_r};
    cpy = '0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; wa = AW'({clr_r[AddrW-1:0], 2'b00}); wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AddrW-1:0] == AddrW'(HeapWords - 1)) st_nxt = S_INIT;
      end
      S_INIT: begin
        // padding already zero; prologue header, prologue footer and epilogue in turn
        we = 1'b1;
        unique case (clr_r[1:0])
          2'd0: begin wa = AW'(4);  wd = 32'd8 | TagUsed; end
          2'd1: begin wa = AW'(8);  wd = 32'd8 | TagUsed; end
          default: begin wa = AW'(12); wd = TagUsed; end
        endcase
        clr_nxt = clr_r + 1'b1;
        if (clr_r[1:0] == 2'd2) begin
          brk_nxt = AW'(16);
          a_nxt = {15'd0, chunk_r};
          gret_nxt = RET_INIT;
          st_nxt = S_GR0;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          req_nxt = in_ch.data;
          st_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt = '{result_address: 16'd0, copy_bytes: 16'd0, status: ST_DONE};
        need_nxt = block_for(req_r.request_bytes);
        ptr_nxt = AW'(req_r.block_address);
        case (req_r.mode)
          MODE_ALLOC: begin aret_nxt = RET_ALLOC; st_nxt = S_FF0; end
          MODE_FREE: begin
            if (req_r.block_address == 16'd0) st_nxt = S_OUT;
            else begin mret_nxt = RET_FREE; st_nxt = S_FR0; end
          end
          MODE_REALLOC: begin
            if (req_r.block_address == 16'd0) begin
              aret_nxt = RET_ALLOC; st_nxt = S_FF0;
            end else if (req_r.request_bytes == 16'd0) begin
              mret_nxt = RET_FREE; st_nxt = S_FR0;
            end else st_nxt = S_RA0;
          end
          default: st_nxt = S_OUT;
        endcase
        if ((req_r.mode == MODE_ALLOC || (req_r.mode == MODE_REALLOC &&
             req_r.block_address == 16'd0)) && req_r.request_bytes == 16'd0) begin
          res_nxt.status = ST_NULL;
          st_nxt = S_OUT;
        end
        bp_nxt = AW'(8);
      end
      // ---- grow: a_r holds byte request, gret_r the caller
      S_GR0: begin
        if ({1'b0, brk_r} + {1'b0, gsz} > (AW+1)'(HeapWords * 4)) begin
          bp_nxt = '0;
          st_nxt = S_GR3;
        end else begin
          bp_nxt = brk_r;
          sz_nxt = 32'(gsz);
          brk_nxt = brk_r + gsz;
          we = 1'b1; wa = brk_r - AW'(4); wd = 32'(gsz);
          st_nxt = S_GR1;
        end
      end
      S_GR1: begin
        we = 1'b1; wa = bp_r + AW'(sz_r) - AW'(8); wd = sz_r;
        st_nxt = S_GR2;
      end
      S_GR2: begin
        we = 1'b1; wa = bp_r + AW'(sz_r) - AW'(4); wd = TagUsed;
        mret_nxt = gret_r;
        st_nxt = S_MG0;
      end
      S_GR3: begin
        // grow failed
        unique case (gret_r)
          RET_INIT:  st_nxt = S_IDLE;
          RET_ALLOC: begin res_nxt.status = ST_NOMEM; st_nxt = S_OUT; end
          default: begin res_nxt.status = ST_NOMEM; st_nxt = S_OUT; end
        endcase
      end
      // ---- merge bp_r; result in bp_r; returns by mret_r
      S_MG0: begin ra = bp_r - AW'(8); st_nxt = S_MG1; end
      S_MG1: begin
        p_nxt = bp_r - AW'(rq & SizeMask);
        ra = bp_r - AW'(4); st_nxt = S_MG2;
      end
      S_MG2: begin
        sz_nxt = rq & SizeMask;
        n_nxt = bp_r + AW'(rq & SizeMask);
        ra = p_r - AW'(4); st_nxt = S_MG3;
      end
      S_MG3: begin
        a_nxt = rq & SizeMask;   // prev size
        ra = p_r + AW'(rq & SizeMask) - AW'(8); st_nxt = S_MG4;
      end
      S_MG4: begin
        pu_nxt = rq[0];
        ra = n_r - AW'(4); st_nxt = S_MG5;
      end
      S_MG5: begin
        b_nxt = rq & SizeMask;   // next size
        if (pu_r && rq[0]) st_nxt = S_MG8;
        else if (pu_r) begin
          sz_nxt = sz_r + (rq & SizeMask);
          we = 1'b1; wa = bp_r - AW'(4); wd = sz_r + (rq & SizeMask);
          st_nxt = S_MG6;
        end else if (rq[0]) begin
          sz_nxt = sz_r + a_r;
          we = 1'b1; wa = bp_r + AW'(sz_r) - AW'(8); wd = sz_r + a_r;
          st_nxt = S_MG7;
        end else begin
          sz_nxt = sz_r + a_r + (rq & SizeMask);
          we = 1'b1; wa = p_r - AW'(4); wd = sz_r + a_r + (rq & SizeMask);
          st_nxt = S_MG7;
          pu_nxt = 1'b0; ok_nxt = 1'b1;
        end
        if (!(pu_r && rq[0]) && !pu_r && !rq[0]) ok_nxt = 1'b1;
        else ok_nxt = 1'b0;
      end
      S_MG6: begin
        // footer of new header size: bp + sz - 8
        we = 1'b1; wa = bp_r + AW'(sz_r) - AW'(8); wd = sz_r;
        st_nxt = S_MG8;
      end
      S_MG7: begin
        we = 1'b1; wd = sz_r;
        if (ok_r) wa = n_r + AW'(b_r) - AW'(8);
        else wa = p_r - AW'(4);
        bp_nxt = p_r;
        st_nxt = S_MG8;
      end
      S_MG8: begin
        unique case (mret_r)
          RET_INIT: st_nxt = S_IDLE;
          RET_ALLOC: st_nxt = S_CV0;
          RET_RA: st_nxt = S_RA4;
          default: st_nxt = (req_r.mode == MODE_REALLOC &&
                             req_r.request_bytes != 16'd0) ? S_RA7 : S_OUT;
        endcase
        if (mret_r == RET_FREE && req_r.mode == MODE_REALLOC &&
            req_r.request_bytes == 16'd0) res_nxt.status = ST_NULL;
      end
      // ---- first fit from bp_r
      S_FF0: begin ra = bp_r - AW'(4); st_nxt = S_FF1; end
      S_FF1: begin
        if ((rq & SizeMask) == 32'd0) begin
          a_nxt = ext;
          gret_nxt = RET_ALLOC;
          st_nxt = S_GR0;
        end else if (!rq[0] && need_r <= (rq & SizeMask)) st_nxt = S_CV0;
        else begin
          bp_nxt = bp_r + AW'(rq & SizeMask);
          st_nxt = S_FF0;
        end
      end
      // ---- carve need_r out of bp_r
      S_CV0: begin ra = bp_r - AW'(4); st_nxt = S_CV1; end
      S_CV1: begin
        a_nxt = rq & SizeMask;
        if ((rq & SizeMask) - need_r >= 32'd16) begin
          we = 1'b1; wa = bp_r - AW'(4); wd = need_r | TagUsed;
          st_nxt = S_CV2;
        end else begin
          we = 1'b1; wa = bp_r - AW'(4); wd = (rq & SizeMask) | TagUsed;
          st_nxt = S_CV4;
        end
      end
      S_CV2: begin
        we = 1'b1; wa = bp_r + AW'(need_r) - AW'(8); wd = need_r | TagUsed;
        st_nxt = S_CV3;
      end
      S_CV3: begin
        we = 1'b1; wa = bp_r + AW'(need_r) - AW'(4); wd = a_r - need_r;
        a_nxt = 32'd0;
        st_nxt = S_AL0;
        // remaining footer
        b_nxt = a_r - need_r;
      end
      S_CV4: begin
        we = 1'b1; wa = bp_r + AW'(a_r) - AW'(8); wd = a_r | TagUsed;
        b_nxt = 32'd0;
        st_nxt = S_AL0;
      end
      S_AL0: begin
        if (b_r != 32'd0) begin
          we = 1'b1; wa = bp_r + AW'(need_r) + AW'(b_r) - AW'(8); wd = b_r;
        end
        res_nxt.result_address = bp_r[15:0];
        res_nxt.status = ST_DONE;
        if (req_r.mode == MODE_REALLOC && req_r.block_address != 16'd0) begin
          cpy = (old_r < 32'd8 || {16'd0, req_r.request_bytes} < old_r - 32'd8) ?
                {16'd0, req_r.request_bytes} : old_r - 32'd8;
          res_nxt.copy_bytes = cpy[15:0];
          bp_nxt = ptr_r;
          st_nxt = S_FR0;
        end else st_nxt = S_OUT;
      end
      // ---- free bp taken from ptr_r
      S_FR0: begin
        bp_nxt = ptr_r; ra = ptr_r - AW'(4); mret_nxt = RET_FREE; st_nxt = S_FR1;
      end
      S_FR1: begin
        sz_nxt = rq & SizeMask;
        we = 1'b1; wa = bp_r - AW'(4); wd = rq & SizeMask; st_nxt = S_FR2;
      end
      S_FR2: begin
        we = 1'b1; wa = bp_r + AW'(sz_r) - AW'(8); wd = sz_r; st_nxt = S_MG0;
      end
      // ---- reallocate in place, else allocate anew and free the old block
      S_RA0: begin ra = ptr_r - AW'(4); st_nxt = S_RA1; end
      S_RA1: begin
        old_nxt = rq & SizeMask;
        if ((rq & SizeMask) >= need_r) begin
          res_nxt.result_address = ptr_r[15:0]; st_nxt = S_OUT;
        end else begin
          n_nxt = ptr_r + AW'(rq & SizeMask);
          ra = ptr_r + AW'(rq & SizeMask) - AW'(4);
          st_nxt = S_RA2;
        end
      end
      S_RA2: begin
        if ((rq & SizeMask) == 32'd0) begin
          a_nxt = ((need_r - old_r) & 32'hFFFF_FFFC) + 32'd4;
          gret_nxt = RET_RA;
          st_nxt = S_GR0;
        end else begin
          b_nxt = rq; st_nxt = S_RA5;
        end
      end
      S_RA4: begin
        // after grow+merge re-read the successor
        ra = ptr_r + AW'(old_r) - AW'(4); st_nxt = S_RA3;
      end
      S_RA3: begin b_nxt = rq; st_nxt = S_RA5; end
      S_RA5: begin
        if (!b_r[0] && old_r + (b_r & SizeMask) >= need_r) begin
          sz_nxt = old_r + (b_r & SizeMask);
          we = 1'b1; wa = ptr_r - AW'(4); wd = (old_r + (b_r & SizeMask)) | TagUsed;
          st_nxt = S_RA6;
        end else begin
          bp_nxt = AW'(8); aret_nxt = RET_ALLOC; st_nxt = S_FF0;
        end
      end
      S_RA6: begin
        we = 1'b1; wa = ptr_r + AW'(sz_r) - AW'(8); wd = sz_r | TagUsed;
        res_nxt.result_address = ptr_r[15:0]; st_nxt = S_OUT;
      end
      S_RA7: st_nxt = S_OUT;
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    rd_valid_nxt = !ra[AW-1] && (ra[AW-1:2] < AW'(HeapWords));
  end

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken with result pending");
  a_brk_grows: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_CLR && st_r != S_INIT |-> brk_r >= $past(brk_r))
    else $error("break shrank");
endmodule
`default_nettype wire
